@@ rtl/deadband_change_reporter_defines.svh @@
// Assertion macros for the deadband change reporter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DEADBAND_CHANGE_REPORTER_DEFINES_SVH
`define DEADBAND_CHANGE_REPORTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dcr_pkg.sv @@
// Package for the deadband change reporter: field widths, transaction
// structs, configuration register indexes and the per-quantity debounce step.
// No dependencies.
`default_nettype none

package dcr_pkg;

  localparam int METER_W    = 3;
  localparam int CHAN_W     = 2;
  localparam int VOLT_W     = 16;
  localparam int CURR_W     = 16;
  localparam int PF_W       = 10;
  localparam int CNT_W      = 8;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_STEP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_STEP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PF_STEP       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = CFG_IDX_W'(4);

  typedef struct packed {
    logic [METER_W-1:0] meter_index;
    logic [CHAN_W-1:0]  channel_index;
    logic [VOLT_W-1:0]  voltage_sample;
    logic [CURR_W-1:0]  current_sample;
    logic [PF_W-1:0]    pf_sample;
    logic               last_channel;
  } in_t;

  typedef struct packed {
    logic [METER_W-1:0] out_meter;
    logic [CHAN_W-1:0]  out_channel;
    logic               voltage_changed;
    logic               current_changed;
    logic               pf_changed;
    logic               report_meter;
    logic [VOLT_W-1:0]  held_voltage;
    logic [CURR_W-1:0]  held_current;
    logic [PF_W-1:0]    held_pf;
  } out_t;

  typedef struct packed {
    logic             changed;
    logic [VAL_W-1:0] held;
    logic [CNT_W-1:0] count;
  } track_t;

  function automatic track_t track(input logic [VAL_W-1:0] sample,
                                   input logic [VAL_W-1:0] held,
                                   input logic [VAL_W-1:0] step,
                                   input logic [CNT_W-1:0] count,
                                   input logic [CNT_W-1:0] confirm);
    track_t           res;
    logic [VAL_W-1:0] diff;
    logic [CNT_W-1:0] cnt_inc;
    res.changed = 1'b0;
    res.held    = held;
    res.count   = count;
    diff        = (sample >= held) ? (sample - held) : (held - sample);
    cnt_inc     = (count < confirm) ? (count + CNT_W'(1)) : count;
    if (step == '0) begin
      res.count = '0;
    end else if (diff < step) begin
      res.count = '0;
    end else begin
      res.count = cnt_inc;
      if (cnt_inc == confirm) begin
        res.changed = 1'b1;
        res.held    = sample;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/deadband_change_reporter.sv @@
// Deadband change reporter: per meter/channel debounce of voltage, current
// and power factor with per-meter report flag. Uses dcr_pkg and the
// assertion macros in deadband_change_reporter_defines.svh.
//
//   port group | direction | handshake          | payload
//   in_        | sink      | in_valid/in_ready  | in_data (dcr_pkg::in_t)
//   out_       | source    | out_valid/out_ready| out_data (dcr_pkg::out_t)
//   cfg_       | sink      | cfg_we             | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while the output is not stalled; out_valid rises
// once an accepted transaction moves from the input register to the result register.
// The table lookup, three subtract-compare-count paths and the write-back
// sit between those two registers; state is updated as the result registers.
// Synchronous reset clears config, all table entries and pending flags.
// A stalled output holds its transaction while the input register still
// takes one more; in_ready drops only when both are full.
`default_nettype none

module deadband_change_reporter #(
  parameter int METER_COUNT   = 8,
  parameter int CHANNEL_COUNT = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire dcr_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output dcr_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dcr_pkg::*;

  localparam int METERS_USED = (METER_COUNT < (1 << METER_W)) ? METER_COUNT : (1 << METER_W);
  localparam int CHANS_USED  = (CHANNEL_COUNT < (1 << CHAN_W)) ? CHANNEL_COUNT : (1 << CHAN_W);
  localparam int SLOTS       = METERS_USED * CHANS_USED;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MTR_IDX_W   = (METERS_USED > 1) ? $clog2(METERS_USED) : 1;

  logic               enable_r;
  logic [VOLT_W-1:0]  vstep_r;
  logic [CURR_W-1:0]  cstep_r;
  logic [PF_W-1:0]    pstep_r;
  logic [CNT_W-1:0]   confirm_r;

  logic [VOLT_W-1:0]  rep_v_r [SLOTS];
  logic [CURR_W-1:0]  rep_c_r [SLOTS];
  logic [PF_W-1:0]    rep_p_r [SLOTS];
  logic [CNT_W-1:0]   cnt_v_r [SLOTS];
  logic [CNT_W-1:0]   cnt_c_r [SLOTS];
  logic [CNT_W-1:0]   cnt_p_r [SLOTS];
  logic [METERS_USED-1:0] pend_r;

  logic               s1_valid_r;
  in_t                s1_r;
  logic               out_valid_r;
  out_t               out_r;

  logic               adv;
  logic               s1_fire;
  logic               in_range;
  logic               upd;
  logic [SLOT_W-1:0]  slot;
  logic [MTR_IDX_W-1:0] mtr;
  track_t             tv;
  track_t             tc;
  track_t             tp;
  logic               any_chg;
  logic               pend_nxt;
  out_t               out_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign s1_fire   = s1_valid_r && adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_range = ({1'b0, s1_r.meter_index} < (METER_W+1)'(METERS_USED)) &&
                    ({1'b0, s1_r.channel_index} < (CHAN_W+1)'(CHANS_USED));
  assign mtr      = MTR_IDX_W'(s1_r.meter_index);
  assign slot     = SLOT_W'(int'(s1_r.meter_index) * CHANS_USED + int'(s1_r.channel_index));
  assign upd      = s1_fire && in_range && enable_r;

  assign tv = track(VAL_W'(s1_r.voltage_sample), VAL_W'(rep_v_r[slot]), VAL_W'(vstep_r),
                    cnt_v_r[slot], confirm_r);
  assign tc = track(VAL_W'(s1_r.current_sample), VAL_W'(rep_c_r[slot]), VAL_W'(cstep_r),
                    cnt_c_r[slot], confirm_r);
  assign tp = track(VAL_W'(s1_r.pf_sample), VAL_W'(rep_p_r[slot]), VAL_W'(pstep_r),
                    cnt_p_r[slot], confirm_r);

  assign any_chg  = tv.changed || tc.changed || tp.changed;
  assign pend_nxt = pend_r[mtr] || any_chg;

  always_comb begin
    out_nxt             = '0;
    out_nxt.out_meter   = s1_r.meter_index;
    out_nxt.out_channel = s1_r.channel_index;
    if (in_range) begin
      if (enable_r) begin
        out_nxt.voltage_changed = tv.changed;
        out_nxt.current_changed = tc.changed;
        out_nxt.pf_changed      = tp.changed;
        out_nxt.report_meter    = s1_r.last_channel && pend_nxt;
        out_nxt.held_voltage    = VOLT_W'(tv.held);
        out_nxt.held_current    = CURR_W'(tc.held);
        out_nxt.held_pf         = PF_W'(tp.held);
      end else begin
        out_nxt.held_voltage    = rep_v_r[slot];
        out_nxt.held_current    = rep_c_r[slot];
        out_nxt.held_pf         = rep_p_r[slot];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      vstep_r     <= '0;
      cstep_r     <= '0;
      pstep_r     <= '0;
      confirm_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rep_v_r[i] <= '0;
        rep_c_r[i] <= '0;
        rep_p_r[i] <= '0;
        cnt_v_r[i] <= '0;
        cnt_c_r[i] <= '0;
        cnt_p_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REPORT_ENABLE: enable_r  <= cfg_wdata[0];
          CFG_VOLTAGE_STEP:  vstep_r   <= cfg_wdata[VOLT_W-1:0];
          CFG_CURRENT_STEP:  cstep_r   <= cfg_wdata[CURR_W-1:0];
          CFG_PF_STEP:       pstep_r   <= cfg_wdata[PF_W-1:0];
          CFG_CONFIRM_COUNT: confirm_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (upd) begin
        rep_v_r[slot] <= VOLT_W'(tv.held);
        rep_c_r[slot] <= CURR_W'(tc.held);
        rep_p_r[slot] <= PF_W'(tp.held);
        cnt_v_r[slot] <= tv.count;
        cnt_c_r[slot] <= tc.count;
        cnt_p_r[slot] <= tp.count;
        pend_r[mtr]   <= s1_r.last_channel ? 1'b0 : pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_fire) begin
      out_r <= out_nxt;
    end
  end

`include "deadband_change_reporter_defines.svh"

  `DCR_ASSERT_NOW(a_ready_when_out_empty, !out_valid_r, in_ready, "in_ready low with empty output")
  `DCR_ASSERT_NEXT(a_advance_fills_out, s1_fire, out_valid_r, "advanced transaction lost")
  `DCR_ASSERT_NOW(a_flags_in_range,
    out_valid_r && (out_r.voltage_changed || out_r.current_changed || out_r.pf_changed ||
    out_r.report_meter),
    ({1'b0, out_r.out_meter} < (METER_W+1)'(METERS_USED)) &&
    ({1'b0, out_r.out_channel} < (CHAN_W+1)'(CHANS_USED)),
    "change flag on out-of-range index")

endmodule

`default_nettype wire
